FILE: rtl/core/rtxq_pkg.sv
// Shared types, constants and helper functions for the xterm-256 colour quantiser.
package rtxq_pkg;

  localparam int CHAN_W     = 8;
  localparam int IN_W       = 16;
  localparam int IDX_W      = 8;
  localparam int END_W      = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int DIGIT_W    = 3;
  localparam int STEP_W     = 5;
  localparam int SQ_W       = 16;
  localparam int DIST_W     = 18;
  localparam int COEF_W     = 24;
  localparam int ACC_W      = 32;
  localparam int REM_W      = 33;
  localparam int CNT_W      = 3;

  // reciprocal estimate of the luma quotient from the top dividend bits
  localparam int HI_LSB      = 16;
  localparam int EST_W       = 28;
  localparam int RECIP_SHIFT = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_INDEX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_INDEX   = 2'd1;

  localparam logic [IDX_W-1:0] FIRST_RESET = 8'd16;
  localparam logic [END_W-1:0] END_RESET   = 9'd256;

  localparam logic [IDX_W-1:0] CUBE_BASE  = 8'd16;
  localparam logic [IDX_W-1:0] GRAY_BASE  = 8'd232;
  localparam logic [IDX_W-1:0] LAST_INDEX = 8'd255;

  // luma weights, numerator of the fixed-point gray estimate
  localparam logic [COEF_W-1:0] COEF_RED   = 24'd2613072;
  localparam logic [COEF_W-1:0] COEF_GREEN = 24'd8788810;
  localparam logic [COEF_W-1:0] COEF_BLUE  = 24'd887015;
  localparam logic [REM_W-1:0]  LUMA_DEN   = 33'd12288897;
  localparam logic [REM_W-1:0]  LUMA_DEN2  = 33'd24577794;
  // floor(2^36 / LUMA_DEN2): estimate is low by at most one
  localparam logic [EST_W-1:0]  LUMA_RECIP = 28'd2795;

  localparam logic [1:0] SEL_RED   = 2'd0;
  localparam logic [1:0] SEL_GREEN = 2'd1;
  localparam logic [1:0] SEL_BLUE  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAC,
    ST_DIV_INIT,
    ST_DIV_EST,
    ST_DIV_FIX,
    ST_GSTEP,
    ST_EVAL_CUBE,
    ST_EVAL_GRAY,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    EV_SCAN,
    EV_CUBE,
    EV_GRAY
  } ev_kind_t;

  typedef struct packed {
    logic              load;
    logic              mac;
    logic [1:0]        mac_sel;
    logic              div_init;
    logic              div_est;
    logic              div_fix;
    logic              gstep;
    logic              eval;
    ev_kind_t          ev_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic fast;
    logic scan_last;
  } dp_status_t;

  function automatic logic [CHAN_W-1:0] sat_channel(input logic signed [IN_W-1:0] v);
    logic [CHAN_W-1:0] r;
    if (v[IN_W-1])
      r = '0;
    else if (v > 16'sd255)
      r = 8'd255;
    else
      r = v[CHAN_W-1:0];
    return r;
  endfunction

  // nearest cube level per channel
  function automatic logic [DIGIT_W-1:0] cube_step(input logic [CHAN_W-1:0] c);
    logic [DIGIT_W-1:0] s;
    if (c < 8'd48)       s = 3'd0;
    else if (c < 8'd115) s = 3'd1;
    else if (c < 8'd155) s = 3'd2;
    else if (c < 8'd195) s = 3'd3;
    else if (c < 8'd235) s = 3'd4;
    else                 s = 3'd5;
    return s;
  endfunction

  function automatic logic [CHAN_W-1:0] cube_level(input logic [DIGIT_W-1:0] d);
    logic [CHAN_W-1:0] v;
    case (d)
      3'd0:    v = 8'd0;
      3'd1:    v = 8'd95;
      3'd2:    v = 8'd135;
      3'd3:    v = 8'd175;
      3'd4:    v = 8'd215;
      default: v = 8'd255;
    endcase
    return v;
  endfunction

  // (gray-3)/10 clamped to 0..23, as a row of threshold compares
  function automatic logic [STEP_W-1:0] gray_step(input logic [CHAN_W-1:0] g);
    logic [STEP_W-1:0] s;
    s = '0;
    for (int k = 1; k < 24; k++) begin
      if ({1'b0, g} >= 9'(3 + 10 * k))
        s = STEP_W'(k);
    end
    return s;
  endfunction

  function automatic logic [CHAN_W-1:0] gray_level(input logic [STEP_W-1:0] k);
    logic [CHAN_W-1:0] kw;
    kw = {3'b000, k};
    return 8'd8 + (kw * 8'd10);
  endfunction

  function automatic logic [SQ_W-1:0] sq_diff(input logic [CHAN_W-1:0] a,
                                              input logic [CHAN_W-1:0] b);
    logic [CHAN_W-1:0] d;
    logic [SQ_W-1:0]   w;
    d = (a > b) ? (a - b) : (b - a);
    w = {8'b0, d};
    return w * w;
  endfunction

endpackage

FILE: rtl/core/rgb_to_xterm256_quantizer_top.sv
// Top level of the RGB to xterm-256 colour quantiser.
//
// A word is taken at a clock edge with start high and busy low: in_red,
// in_green and in_blue are signed and saturated to 0..255 on entry.
// One result word follows, shown for a single cycle with done high:
// out_red/out_green/out_blue are the saturated channels, color_index the
// chosen palette entry. The receiver cannot hold results off.
// Steps from the accepting edge to the done cycle:
//   full window (first_index 16, end_index 256): three multiply-accumulate
//   steps for luma, one setup, a reciprocal estimate and a correction
//   step, gray step, two candidate evaluations and drain;
//   any other window: one palette entry per cycle over all 240
//   entries 16..255 through the distance unit, plus drain.
// busy stays high until done has been shown; the next word is accepted
// the cycle after done.
// Register writes (cfg_write, cfg_index, cfg_data) take effect at once;
// the user must make them while idle (the block does not enforce it);
// unknown indexes are dropped. Reset returns controller to idle, window 16..256.
module rgb_to_xterm256_quantizer_top import rtxq_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic signed [IN_W-1:0] in_red,
  input  logic signed [IN_W-1:0] in_green,
  input  logic signed [IN_W-1:0] in_blue,
  input  logic                   cfg_write,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic                   done,
  output logic [CHAN_W-1:0]      out_red,
  output logic [CHAN_W-1:0]      out_green,
  output logic [CHAN_W-1:0]      out_blue,
  output logic [IDX_W-1:0]       color_index
);

  dp_cmd_t    cmd;
  dp_status_t status;

  rtxq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .busy   (busy),
    .done   (done),
    .cmd    (cmd)
  );

  rtxq_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_red      (in_red),
    .in_green    (in_green),
    .in_blue     (in_blue),
    .cmd         (cmd),
    .status      (status),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .color_index (color_index)
  );

endmodule

FILE: rtl/core/rtxq_datapath.sv
// Datapath: config registers, luma accumulate and divide, distance unit and best-match tracking.
module rtxq_datapath import rtxq_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  input  logic signed [IN_W-1:0]      in_red,
  input  logic signed [IN_W-1:0]      in_green,
  input  logic signed [IN_W-1:0]      in_blue,
  input  dp_cmd_t                     cmd,
  output dp_status_t                  status,
  output logic [CHAN_W-1:0]           out_red,
  output logic [CHAN_W-1:0]           out_green,
  output logic [CHAN_W-1:0]           out_blue,
  output logic [IDX_W-1:0]            color_index
);

  logic [IDX_W-1:0]   first_index;
  logic [END_W-1:0]   end_index;

  logic [CHAN_W-1:0]  red, green, blue;
  logic [DIGIT_W-1:0] cube_r, cube_g, cube_b;
  logic [ACC_W-1:0]   acc;
  logic [REM_W-1:0]   rem;
  logic [IDX_W-1:0]   quo;
  logic [STEP_W-1:0]  gstep;

  logic [IDX_W-1:0]   scan_idx;
  logic [DIGIT_W-1:0] scan_r, scan_g, scan_b;

  logic               ev_valid;
  logic [IDX_W-1:0]   ev_idx;
  logic [DIST_W-1:0]  ev_dist;
  logic [DIST_W-1:0]  least;
  logic [IDX_W-1:0]   best;

  logic [CHAN_W-1:0]  sat_r, sat_g, sat_b;
  logic [CHAN_W-1:0]  mac_chan;
  logic [COEF_W-1:0]  mac_coef;
  logic [ACC_W-1:0]   mac_prod;
  logic [EST_W-1:0]   est_prod;
  logic [REM_W-1:0]   fix_prod;
  logic [REM_W-1:0]   fix_rem;

  logic               cand_valid;
  logic [IDX_W-1:0]   cand_idx;
  logic [CHAN_W-1:0]  cand_r, cand_g, cand_b;
  logic [DIST_W-1:0]  cand_dist;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      first_index <= FIRST_RESET;
      end_index   <= END_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_FIRST_INDEX: first_index <= cfg_data[IDX_W-1:0];
        CFG_END_INDEX:   end_index   <= cfg_data[END_W-1:0];
        default: ;
      endcase
    end
  end

  assign status.fast      = (first_index == FIRST_RESET) && (end_index == END_RESET);
  assign status.scan_last = (scan_idx == LAST_INDEX);

  assign sat_r = sat_channel(in_red);
  assign sat_g = sat_channel(in_green);
  assign sat_b = sat_channel(in_blue);

  always_comb begin
    case (cmd.mac_sel)
      SEL_RED: begin
        mac_chan = red;
        mac_coef = COEF_RED;
      end
      SEL_GREEN: begin
        mac_chan = green;
        mac_coef = COEF_GREEN;
      end
      SEL_BLUE: begin
        mac_chan = blue;
        mac_coef = COEF_BLUE;
      end
      default: begin
        mac_chan = '0;
        mac_coef = '0;
      end
    endcase
  end

  assign mac_prod = ACC_W'(mac_chan) * ACC_W'(mac_coef);
  assign est_prod = EST_W'(rem[REM_W-1:HI_LSB]) * LUMA_RECIP;
  assign fix_prod = REM_W'(quo) * LUMA_DEN2;
  assign fix_rem  = rem - fix_prod;

  // luma: accumulate, then (2*num + den) / (2*den) by reciprocal estimate and one correction
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      red    <= sat_r;
      green  <= sat_g;
      blue   <= sat_b;
      cube_r <= cube_step(sat_r);
      cube_g <= cube_step(sat_g);
      cube_b <= cube_step(sat_b);
      acc    <= '0;
    end else if (cmd.mac) begin
      acc <= acc + mac_prod;
    end
    if (cmd.div_init)
      rem <= {acc, 1'b0} + LUMA_DEN;
    if (cmd.div_est)
      quo <= est_prod[RECIP_SHIFT +: IDX_W];
    else if (cmd.div_fix && (fix_rem >= LUMA_DEN2))
      quo <= quo + 8'd1;
    if (cmd.gstep)
      gstep <= gray_step(quo);
  end

  // candidate entry colour and index
  always_comb begin
    cand_valid = 1'b0;
    cand_idx   = '0;
    cand_r     = '0;
    cand_g     = '0;
    cand_b     = '0;
    case (cmd.ev_kind)
      EV_CUBE: begin
        cand_valid = 1'b1;
        cand_idx   = CUBE_BASE + (8'd36 * {5'b0, cube_r}) + (8'd6 * {5'b0, cube_g})
                     + {5'b0, cube_b};
        cand_r     = cube_level(cube_r);
        cand_g     = cube_level(cube_g);
        cand_b     = cube_level(cube_b);
      end
      EV_GRAY: begin
        cand_valid = 1'b1;
        cand_idx   = GRAY_BASE + {3'b0, gstep};
        cand_r     = gray_level(gstep);
        cand_g     = cand_r;
        cand_b     = cand_r;
      end
      EV_SCAN: begin
        cand_valid = (scan_idx >= first_index) && ({1'b0, scan_idx} < end_index);
        cand_idx   = scan_idx;
        if (scan_idx >= GRAY_BASE) begin
          cand_r = gray_level(STEP_W'(scan_idx - GRAY_BASE));
          cand_g = cand_r;
          cand_b = cand_r;
        end else begin
          cand_r = cube_level(scan_r);
          cand_g = cube_level(scan_g);
          cand_b = cube_level(scan_b);
        end
      end
      default: ;
    endcase
  end

  assign cand_dist = DIST_W'(sq_diff(cand_r, red)) + DIST_W'(sq_diff(cand_g, green))
                   + DIST_W'(sq_diff(cand_b, blue));

  // scan walker: palette index with its base-6 cube digits
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      scan_idx <= CUBE_BASE;
      scan_r   <= '0;
      scan_g   <= '0;
      scan_b   <= '0;
    end else if (cmd.eval && (cmd.ev_kind == EV_SCAN)) begin
      scan_idx <= scan_idx + 8'd1;
      if (scan_b == 3'd5) begin
        scan_b <= '0;
        if (scan_g == 3'd5) begin
          scan_g <= '0;
          scan_r <= (scan_r == 3'd5) ? 3'd0 : scan_r + 3'd1;
        end else begin
          scan_g <= scan_g + 3'd1;
        end
      end else begin
        scan_b <= scan_b + 3'd1;
      end
    end
  end

  // distance stage, then compare stage; earlier entry wins ties
  always_ff @(posedge clk) begin
    if (rst)
      ev_valid <= 1'b0;
    else
      ev_valid <= cmd.eval && cand_valid;
  end

  always_ff @(posedge clk) begin
    ev_idx  <= cand_idx;
    ev_dist <= cand_dist;
    if (cmd.load) begin
      least <= '1;
      best  <= '0;
    end else if (ev_valid && (ev_dist < least)) begin
      least <= ev_dist;
      best  <= ev_idx;
    end
  end

  assign out_red     = red;
  assign out_green   = green;
  assign out_blue    = blue;
  assign color_index = best;

endmodule

FILE: rtl/core/rtxq_ctrl.sv
// Controller: sequences the luma divide and palette evaluation for each word.
module rtxq_ctrl import rtxq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dp_status_t status,
  output logic       busy,
  output logic       done,
  output dp_cmd_t    cmd
);

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    cmd         = '0;
    cmd.ev_kind = EV_SCAN;
    busy        = 1'b1;
    done        = 1'b0;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = status.fast ? ST_MAC : ST_SCAN;
        end
      end
      ST_MAC: begin
        cmd.mac     = 1'b1;
        cmd.mac_sel = cnt[1:0];
        cnt_next    = cnt + 3'd1;
        if (cnt == 3'd2)
          state_next = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_next   = ST_DIV_EST;
      end
      ST_DIV_EST: begin
        cmd.div_est = 1'b1;
        state_next  = ST_DIV_FIX;
      end
      ST_DIV_FIX: begin
        cmd.div_fix = 1'b1;
        state_next  = ST_GSTEP;
      end
      ST_GSTEP: begin
        cmd.gstep  = 1'b1;
        state_next = ST_EVAL_CUBE;
      end
      ST_EVAL_CUBE: begin
        cmd.eval    = 1'b1;
        cmd.ev_kind = EV_CUBE;
        state_next  = ST_EVAL_GRAY;
      end
      ST_EVAL_GRAY: begin
        cmd.eval    = 1'b1;
        cmd.ev_kind = EV_GRAY;
        state_next  = ST_DRAIN;
      end
      ST_SCAN: begin
        cmd.eval    = 1'b1;
        cmd.ev_kind = EV_SCAN;
        if (status.scan_last)
          state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
